// File: src/assert_macros.svh
// Assertion macros shared by the signed integer to radix text core.
// Included by the RTL files that check their own control logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset
`define SICRT_ASSERT_HOLD(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in a cycle implies the consequent in the same cycle
`define SICRT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/sicrt_pkg.sv
// Shared types and constants for the signed integer to radix text core.
// No dependencies; every module of the core imports this package.
`default_nettype none

package sicrt_pkg;

   // Default sizes handed to the top level parameters
   localparam int SICRT_ALPHA_MAX = 128;
   localparam int SICRT_NUM_WIDTH = 32;

   // Command queue depth between front and back (power of two)
   localparam int SICRT_Q_DEPTH = 4;

   // Fixed field widths
   localparam int SYM_W = 8;
   localparam int OP_W  = 2;

   // Operation codes
   localparam logic [OP_W-1:0] OP_START   = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND  = 2'd1;
   localparam logic [OP_W-1:0] OP_CONVERT = 2'd2;

   // Character codes used by the symbol checks and the sign
   localparam logic [SYM_W-1:0] CHAR_PLUS     = 8'h2B;
   localparam logic [SYM_W-1:0] CHAR_MINUS    = 8'h2D;
   localparam logic [SYM_W-1:0] CHAR_CTRL_MAX = 8'd31;
   localparam logic [SYM_W-1:0] CHAR_DEL      = 8'd127;

   // Classified command, without the magnitude
   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [SYM_W-1:0] sym;
      logic             sym_bad;
      logic             neg;
   } sicrt_cmd_type;

endpackage

`default_nettype wire

// File: src/sicrt_front.sv
// Front end: accepts request beats, drops unused operation codes, flags
// illegal symbols and takes the magnitude. Depends on sicrt_pkg.
`default_nettype none

module sicrt_front
   import sicrt_pkg::*;
#(
   parameter int NUM_WIDTH = SICRT_NUM_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((NUM_WIDTH + 15) / 8) * 8 - 1:0] req_tdata,
   input  logic [OP_W-1:0]                     req_tuser,
   output logic                                cmd_valid,
   input  logic                                cmd_ready,
   output sicrt_cmd_type                       cmd,
   output logic [NUM_WIDTH-1:0]                cmd_mag
);

   logic                 slot_v_ff, slot_v_in;
   sicrt_cmd_type        slot_ff, slot_in;
   logic [NUM_WIDTH-1:0] mag_ff, mag_in;

   logic [SYM_W-1:0]     sym;
   logic [NUM_WIDTH-1:0] number;
   logic                 accept;
   logic                 push;
   logic                 op_used;

   assign sym    = req_tdata[SYM_W-1:0];
   assign number = req_tdata[SYM_W +: NUM_WIDTH];
   assign push   = slot_v_ff && cmd_ready;
   assign req_tready = !slot_v_ff || cmd_ready;
   assign accept = req_tvalid && req_tready;
   assign op_used = (req_tuser == OP_START) || (req_tuser == OP_APPEND) ||
                    (req_tuser == OP_CONVERT);

   // Classify the beat; drop it when the operation code means nothing
   always_comb begin
      slot_in         = slot_ff;
      mag_in          = mag_ff;
      slot_v_in       = push ? 1'b0 : slot_v_ff;
      if (accept) begin
         slot_v_in       = op_used;
         slot_in.op      = req_tuser;
         slot_in.sym     = sym;
         slot_in.sym_bad = (sym == CHAR_PLUS) || (sym == CHAR_MINUS) ||
                           (sym <= CHAR_CTRL_MAX) || (sym >= CHAR_DEL);
         slot_in.neg     = number[NUM_WIDTH-1];
         mag_in          = number[NUM_WIDTH-1] ? (~number + 1'b1) : number;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_v_ff <= 1'b0;
      end else begin
         slot_v_ff <= slot_v_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      mag_ff  <= mag_in;
   end

   assign cmd_valid = slot_v_ff;
   assign cmd       = slot_ff;
   assign cmd_mag   = mag_ff;

endmodule

`default_nettype wire

// File: src/sicrt_queue.sv
// Short command queue between the front end and the conversion back end.
// Depends on sicrt_pkg for its depth.
`default_nettype none
`include "assert_macros.svh"

module sicrt_queue
   import sicrt_pkg::*;
#(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DATA_W-1:0] in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DATA_W-1:0] out_data
);

   localparam int PTR_W = $clog2(SICRT_Q_DEPTH);
   localparam int CNT_W = $clog2(SICRT_Q_DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [SICRT_Q_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign in_ready  = (count_ff != CNT_W'(SICRT_Q_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Advance pointers; they wrap naturally at the power-of-two depth
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   // Pointer distance tracks the fill count
   `SICRT_ASSERT_HOLD(a_q_count_ptrs, clock, reset,
      (wr_ptr_ff - rd_ptr_ff) == count_ff[PTR_W-1:0], "queue count disagrees with pointers")

endmodule

`default_nettype wire

// File: src/sicrt_divider.sv
// Restoring divider: one quotient bit per cycle.
// Gives quotient and remainder of a magnitude by the radix. Uses sicrt_pkg.
`default_nettype none
`include "assert_macros.svh"

module sicrt_divider
   import sicrt_pkg::*;
#(
   parameter int NUM_WIDTH = SICRT_NUM_WIDTH,
   parameter int LEN_W     = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_WIDTH-1:0] dividend,
   input  logic [LEN_W-1:0]     divisor,
   output logic                 done,
   output logic [NUM_WIDTH-1:0] quotient,
   output logic [LEN_W-1:0]     remainder
);

   localparam int STEP_W = $clog2(NUM_WIDTH);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [NUM_WIDTH-1:0] quo_ff, quo_in;
   logic [LEN_W-1:0]     rem_ff, rem_in;
   logic [LEN_W-1:0]     div_ff, div_in;

   logic [LEN_W:0]       trial;
   logic [LEN_W:0]       diff;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[NUM_WIDTH-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = (trial >= {1'b0, div_ff});

   // Shift in one dividend bit and subtract the divisor where it fits
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(NUM_WIDTH - 1);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[NUM_WIDTH-2:0], fits};
         rem_in  = fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   // A new division never interrupts one in flight
   `SICRT_ASSERT_IMPL(a_div_no_restart, clock, reset, start, !busy_ff,
      "divider started while busy")

endmodule

`default_nettype wire

// File: src/sicrt_back.sv
// Back end: owns the alphabet, runs the digit loop on the divider and
// emits characters through the output register. Uses sicrt_pkg, sicrt_divider.
`default_nettype none
`include "assert_macros.svh"

module sicrt_back
   import sicrt_pkg::*;
#(
   parameter int ALPHA_MAX = SICRT_ALPHA_MAX,
   parameter int NUM_WIDTH = SICRT_NUM_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   input  sicrt_cmd_type        cmd,
   input  logic [NUM_WIDTH-1:0] cmd_mag,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [SYM_W-1:0]     rsp_tdata,
   output logic                 rsp_tlast
);

   localparam int LEN_W = $clog2(ALPHA_MAX + 1);
   localparam int IDX_W = $clog2(ALPHA_MAX);
   localparam int CNT_W = $clog2(NUM_WIDTH + 1);
   localparam int BUF_W = $clog2(NUM_WIDTH);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DIV   = 5'b00010,
      ST_SIGN  = 5'b00100,
      ST_FETCH = 5'b01000,
      ST_PUT   = 5'b10000
   } sicrt_back_state_type;

   sicrt_back_state_type state_ff, state_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic                 bad_ff, bad_in;
   logic                 neg_ff, neg_in;
   logic [CNT_W-1:0]     ndig_ff, ndig_in;
   logic [BUF_W-1:0]     idx_ff, idx_in;
   logic [255:0]         seen_ff;
   logic [SYM_W-1:0]     alpha_mem [ALPHA_MAX];
   logic [IDX_W-1:0]     dbuf_ff [NUM_WIDTH];
   logic [SYM_W-1:0]     rd_data_ff;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [SYM_W-1:0]     rsp_tdata_ff, rsp_tdata_in;
   logic                 rsp_tlast_ff, rsp_tlast_in;

   logic                 seen_clr, seen_set;
   logic                 tab_we, dbuf_we, rd_en;
   logic [BUF_W-1:0]     rd_ptr;
   logic                 slot_free, load;
   logic                 div_start, div_done;
   logic [NUM_WIDTH-1:0] div_dividend, div_quo;
   logic [LEN_W-1:0]     div_rem;

   sicrt_divider #(
      .NUM_WIDTH (NUM_WIDTH),
      .LEN_W     (LEN_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (len_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign slot_free = !rsp_tvalid_ff || rsp_tready;

   // Sequence commands: alphabet edits, digit loop, character output
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      bad_in       = bad_ff;
      neg_in       = neg_ff;
      ndig_in      = ndig_ff;
      idx_in       = idx_ff;
      cmd_ready    = 1'b0;
      seen_clr     = 1'b0;
      seen_set     = 1'b0;
      tab_we       = 1'b0;
      dbuf_we      = 1'b0;
      rd_en        = 1'b0;
      rd_ptr       = idx_ff;
      div_start    = 1'b0;
      div_dividend = cmd_mag;
      load         = 1'b0;
      rsp_tdata_in = rsp_tdata_ff;
      rsp_tlast_in = rsp_tlast_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               unique case (cmd.op)
                  OP_START: begin
                     seen_clr = 1'b1;
                     len_in   = '0;
                     bad_in   = 1'b0;
                  end
                  OP_APPEND: begin
                     seen_set = 1'b1;
                     if (cmd.sym_bad || seen_ff[cmd.sym] ||
                         (len_ff == LEN_W'(ALPHA_MAX))) begin
                        bad_in = 1'b1;
                     end
                     if (len_ff != LEN_W'(ALPHA_MAX)) begin
                        tab_we = 1'b1;
                        len_in = len_ff + 1'b1;
                     end
                  end
                  OP_CONVERT: begin
                     if (!bad_ff && (len_ff >= LEN_W'(2))) begin
                        div_start = 1'b1;
                        neg_in    = cmd.neg;
                        ndig_in   = '0;
                        state_in  = ST_DIV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) begin
               dbuf_we = 1'b1;
               ndig_in = ndig_ff + 1'b1;
               if (div_quo != '0) begin
                  div_start    = 1'b1;
                  div_dividend = div_quo;
               end else begin
                  idx_in   = ndig_ff[BUF_W-1:0];
                  state_in = neg_ff ? ST_SIGN : ST_FETCH;
               end
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               load         = 1'b1;
               rsp_tdata_in = CHAR_MINUS;
               rsp_tlast_in = 1'b0;
               state_in     = ST_FETCH;
            end
         end
         ST_FETCH: begin
            rd_en    = 1'b1;
            rd_ptr   = idx_ff;
            state_in = ST_PUT;
         end
         ST_PUT: begin
            if (slot_free) begin
               load         = 1'b1;
               rsp_tdata_in = rd_data_ff;
               rsp_tlast_in = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
                  rd_en  = 1'b1;
                  rd_ptr = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_tvalid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_tvalid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         len_ff        <= '0;
         bad_ff        <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         len_ff        <= len_in;
         bad_ff        <= bad_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Seen flags clear all at once on reset and on a start command
   always_ff @(posedge clock) begin
      if (reset || seen_clr) begin
         seen_ff <= '0;
      end else if (seen_set) begin
         seen_ff[cmd.sym] <= 1'b1;
      end
   end

   // Alphabet memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (tab_we) begin
         alpha_mem[len_ff[IDX_W-1:0]] <= cmd.sym;
      end
      if (rd_en) begin
         rd_data_ff <= alpha_mem[dbuf_ff[rd_ptr]];
      end
   end

   // Digit buffer fills least significant digit first
   always_ff @(posedge clock) begin
      if (dbuf_we) begin
         dbuf_ff[ndig_ff[BUF_W-1:0]] <= div_rem[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      neg_ff       <= neg_in;
      ndig_ff      <= ndig_in;
      idx_ff       <= idx_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // Alphabet never grows past its capacity
   `SICRT_ASSERT_HOLD(a_len_cap, clock, reset, len_ff <= LEN_W'(ALPHA_MAX),
      "alphabet length beyond capacity")
   // Output index stays within the digits produced
   `SICRT_ASSERT_IMPL(a_idx_range, clock, reset,
      (state_ff == ST_FETCH) || (state_ff == ST_PUT), CNT_W'(idx_ff) < ndig_ff,
      "digit index beyond digit count")
   // Quotients come back only while the digit loop waits for them
   `SICRT_ASSERT_IMPL(a_done_in_div, clock, reset, div_done, state_ff == ST_DIV,
      "divider result outside digit loop")

endmodule

`default_nettype wire

// File: src/signed_int_to_custom_radix_text_core.sv
// Top level of the signed integer to custom radix text core.
// Depends on sicrt_pkg, sicrt_front, sicrt_queue and sicrt_back.
//
//   channel | dir | handshake             | payload
//   req     | in  | req_tvalid/req_tready | tuser: operation; tdata: symbol, number
//   rsp     | out | rsp_tvalid/rsp_tready | tdata: out_char; tlast: last
//
// Start and append are handled by the back end in its idle state. A conversion of D digits
// divides once per digit in the one-bit-per-cycle divider, then fetches the symbols and
// puts one character a cycle while the output is not stalled, after a minus sign for a
// negative number.
// Synchronous active-high reset clears the alphabet length, invalid flag and seen flags.
// A stalled output holds the back end; the front keeps taking beats until the queue and its slot fill.
`default_nettype none

module signed_int_to_custom_radix_text_core
   import sicrt_pkg::*;
#(
   parameter int ALPHA_MAX = SICRT_ALPHA_MAX,
   parameter int NUM_WIDTH = SICRT_NUM_WIDTH
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // tdata fields from bit 0: symbol (8), number (NUM_WIDTH), zero fill
   input  logic [((NUM_WIDTH + 15) / 8) * 8 - 1:0] req_tdata,
   // tuser fields from bit 0: operation (2)
   input  logic [OP_W-1:0]                         req_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // tdata fields from bit 0: out_char (8)
   output logic [SYM_W-1:0]                        rsp_tdata,
   output logic                                    rsp_tlast
);

   localparam int CMD_W = $bits(sicrt_cmd_type);
   localparam int Q_W   = CMD_W + NUM_WIDTH;

   logic                 f_valid, f_ready;
   sicrt_cmd_type        f_cmd;
   logic [NUM_WIDTH-1:0] f_mag;
   logic                 b_valid, b_ready;
   logic [Q_W-1:0]       q_out;
   sicrt_cmd_type        b_cmd;
   logic [NUM_WIDTH-1:0] b_mag;

   sicrt_front #(
      .NUM_WIDTH  (NUM_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (f_valid),
      .cmd_ready  (f_ready),
      .cmd        (f_cmd),
      .cmd_mag    (f_mag)
   );

   sicrt_queue #(
      .DATA_W    (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   ({f_cmd, f_mag}),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_data  (q_out)
   );

   // Split the queue entry back into command and magnitude
   assign b_cmd = sicrt_cmd_type'(q_out[Q_W-1 -: CMD_W]);
   assign b_mag = q_out[NUM_WIDTH-1:0];

   sicrt_back #(
      .ALPHA_MAX  (ALPHA_MAX),
      .NUM_WIDTH  (NUM_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (b_valid),
      .cmd_ready  (b_ready),
      .cmd        (b_cmd),
      .cmd_mag    (b_mag),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// File: tb/radix_text_checker.sv
// Checker for the signed integer to custom radix text core: watches both streams,
// predicts the text of each conversion and compares every output beat in order.
// Depends on sicrt_pkg for field widths, operation codes and character codes.
`timescale 1ns / 1ps

module radix_text_checker
   import sicrt_pkg::*;
#(
   parameter int ALPHA_MAX = SICRT_ALPHA_MAX,
   parameter int NUM_WIDTH = SICRT_NUM_WIDTH,
   parameter int TDATA_W   = ((NUM_WIDTH + 15) / 8) * 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,
   input  logic [OP_W-1:0]    req_tuser,
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [SYM_W-1:0]   rsp_tdata,
   input  logic               rsp_tlast,
   output int                 mismatch_count,
   output int                 chars_pending
);

   typedef struct packed {
      logic [SYM_W-1:0] ch;
      logic             last;
   } text_char_type;

   // Expected output characters, oldest first
   text_char_type chars_due[$];

   // Shadow of the alphabet state
   logic [SYM_W-1:0] glyphs [ALPHA_MAX];
   bit               seen [256];
   int unsigned      glyph_count;
   bit               alpha_bad;

   initial begin
      mismatch_count = 0;
      chars_pending  = 0;
      glyph_count    = 0;
      alpha_bad      = 1'b0;
      foreach (seen[i]) seen[i] = 1'b0;
   end

   task automatic report_mismatch(input string what, input text_char_type want,
                                  input text_char_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: expected char %h last %b, got char %h last %b",
                  $time, what, want.ch, want.last, got.ch, got.last);
   endtask

   // Queue the characters of one conversion with the current alphabet
   task automatic predict_text(input logic [NUM_WIDTH-1:0] num);
      logic [NUM_WIDTH-1:0] mag;
      logic [NUM_WIDTH-1:0] radix;
      int                   digits [NUM_WIDTH];
      int                   n;
      bit                   neg;
      text_char_type        c;
      neg   = num[NUM_WIDTH-1];
      mag   = neg ? (~num + 1'b1) : num;
      radix = NUM_WIDTH'(glyph_count);
      n     = 0;
      while (n == 0 || mag != 0) begin
         digits[n] = int'(mag % radix);
         mag       = mag / radix;
         n++;
      end
      if (neg) begin
         c.ch   = CHAR_MINUS;
         c.last = 1'b0;
         chars_due.push_back(c);
      end
      for (int i = n - 1; i >= 0; i--) begin
         c.ch   = glyphs[digits[i]];
         c.last = (i == 0);
         chars_due.push_back(c);
      end
   endtask

   // Advance the shadow state by one request beat
   task automatic apply_request(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                                input logic [NUM_WIDTH-1:0] num);
      case (op)
         OP_START: begin
            foreach (seen[i]) seen[i] = 1'b0;
            glyph_count = 0;
            alpha_bad   = 1'b0;
         end
         OP_APPEND: begin
            if (sym == CHAR_PLUS || sym == CHAR_MINUS || sym <= CHAR_CTRL_MAX ||
                sym >= CHAR_DEL || seen[sym])
               alpha_bad = 1'b1;
            seen[sym] = 1'b1;
            if (glyph_count >= ALPHA_MAX) begin
               alpha_bad = 1'b1;
            end else begin
               glyphs[glyph_count] = sym;
               glyph_count++;
            end
         end
         OP_CONVERT: begin
            if (!alpha_bad && glyph_count >= 2)
               predict_text(num);
         end
         default: ;
      endcase
   endtask

   // Check output beats first, then take in the request beat of the same edge
   always @(posedge clock) begin
      text_char_type got;
      text_char_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.ch   = rsp_tdata;
            got.last = rsp_tlast;
            if (chars_due.size() == 0) begin
               want = '0;
               report_mismatch("unexpected output beat", want, got);
            end else begin
               want = chars_due.pop_front();
               if (got.ch !== want.ch || got.last !== want.last)
                  report_mismatch("output beat differs", want, got);
            end
         end
         if (req_tvalid && req_tready)
            apply_request(req_tuser, req_tdata[SYM_W-1:0], req_tdata[SYM_W +: NUM_WIDTH]);
      end
      chars_pending <= chars_due.size();
   end

endmodule

// File: tb/signed_int_to_custom_radix_text_core_tb.sv
// Top of the testbench for the signed integer to custom radix text core: clock,
// reset, request stimulus with bursty valid, output backpressure and the verdict.
// Depends on sicrt_pkg, radix_text_checker and the core itself.
`timescale 1ns / 1ps

module signed_int_to_custom_radix_text_core_tb;
   import sicrt_pkg::*;

   localparam int NUMW         = SICRT_NUM_WIDTH;
   localparam int TDATA_W      = ((NUMW + 15) / 8) * 8;
   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 11;
   localparam int ITEM_TARGET  = 460;
   localparam int DRAIN_CYCLES = 1200;
   localparam int CYCLE_LIMIT  = 3_000_000;

   // Operation code the core ignores
   localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [TDATA_W-1:0] req_tdata;   // symbol (8), number (NUMW), zero fill
   logic [OP_W-1:0]    req_tuser;   // operation (2)
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [SYM_W-1:0]   rsp_tdata;   // out_char (8)
   logic               rsp_tlast;

   int mismatch_count;
   int chars_pending;
   int cycle_count = 0;
   int items_sent  = 0;
   int burst_left  = 0;
   int ready_mode  = 0;
   int mode_left   = 0;

   // Valid alphabet symbols, reshuffled for each new alphabet
   logic [SYM_W-1:0] glyph_pool[$];

   always #(HALF_PERIOD) clock = ~clock;

   signed_int_to_custom_radix_text_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   radix_text_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .chars_pending  (chars_pending)
   );

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Output backpressure: switch to a randomly chosen stall mode whenever the mode counter runs out
   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode <= $urandom_range(0, 3);
         mode_left  <= $urandom_range(20, 200);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (ready_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 3) != 0);
         2:       rsp_tready <= ($urandom_range(0, 1) != 0);
         default: rsp_tready <= (cycle_count % 5 != 0);
      endcase
   end

   // Drive one request beat, with a random gap at the start of each burst
   task automatic send_beat(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                            input logic [NUMW-1:0] num);
      int               gap;
      logic [TDATA_W-1:0] word;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      word                   = '0;
      word[SYM_W-1:0]        = sym;
      word[SYM_W +: NUMW]    = num;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Hold the input until every expected character has come out
   task automatic wait_for_text();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (chars_pending != 0) @(posedge clock);
   endtask

   function automatic logic [NUMW-1:0] rand_number();
      logic [NUMW-1:0] v;
      case ($urandom_range(0, 4))
         0: v = $urandom;
         1: v = $urandom_range(0, 1000);
         2: begin
            v = $urandom_range(1, 1000);
            v = -v;
         end
         3: begin
            case ($urandom_range(0, 4))
               0:       v = '0;
               1:       v = '1;
               2:       v = 1;
               3:       v = {1'b1, {(NUMW - 1){1'b0}}};
               default: v = {1'b0, {(NUMW - 1){1'b1}}};
            endcase
         end
         default: begin
            v = $urandom >> $urandom_range(0, NUMW - 1);
            if ($urandom_range(0, 1) != 0) v = -v;
         end
      endcase
      return v;
   endfunction

   function automatic int alpha_size();
      if ($urandom_range(0, 4) == 0) return $urandom_range(2, glyph_pool.size());
      return $urandom_range(2, 16);
   endfunction

   // Start a fresh alphabet of distinct valid symbols; optionally slip in a bad one
   task automatic load_alphabet(input int size, input int bad_at);
      int               j;
      logic [SYM_W-1:0] t;
      logic [SYM_W-1:0] bad;
      for (int i = glyph_pool.size() - 1; i > 0; i--) begin
         j             = $urandom_range(0, i);
         t             = glyph_pool[i];
         glyph_pool[i] = glyph_pool[j];
         glyph_pool[j] = t;
      end
      send_beat(OP_START, SYM_W'($urandom), $urandom);
      for (int i = 0; i <= size; i++) begin
         if (i == bad_at) begin
            case ($urandom_range(0, 4))
               0:       bad = CHAR_PLUS;
               1:       bad = CHAR_MINUS;
               2:       bad = SYM_W'($urandom_range(0, CHAR_CTRL_MAX));
               3:       bad = SYM_W'($urandom_range(CHAR_DEL, 255));
               default: bad = glyph_pool[$urandom_range(0, bad_at - 1)];
            endcase
            send_beat(OP_APPEND, bad, $urandom);
         end
         if (i < size) send_beat(OP_APPEND, glyph_pool[i], $urandom);
      end
   endtask

   task automatic send_converts(input int count);
      repeat (count) send_beat(OP_CONVERT, SYM_W'($urandom), rand_number());
   endtask

   initial begin
      bit paused;
      bit overfilled;
      int size;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= OP_START;
      req_tdata  <= '0;
      paused     = 1'b0;
      overfilled = 1'b0;
      for (int c = CHAR_CTRL_MAX + 1; c < CHAR_DEL; c++)
         if (c != CHAR_PLUS && c != CHAR_MINUS) glyph_pool.push_back(SYM_W'(c));
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty and one-symbol alphabets give nothing
      send_beat(OP_CONVERT, SYM_W'($urandom), 5);
      send_beat(OP_APPEND, "0", $urandom);
      send_beat(OP_CONVERT, SYM_W'($urandom), 5);
      // Binary alphabet: zero, minus one, the extremes
      send_beat(OP_APPEND, "1", $urandom);
      send_beat(OP_CONVERT, 8'hFF, '0);
      send_beat(OP_CONVERT, 8'h00, '1);
      send_beat(OP_CONVERT, SYM_W'($urandom), {1'b1, {(NUMW - 1){1'b0}}});
      send_beat(OP_CONVERT, SYM_W'($urandom), {1'b0, {(NUMW - 1){1'b1}}});
      // Reserved operation is dropped
      send_beat(OP_RESERVED, 8'hFF, '1);
      send_beat(OP_CONVERT, SYM_W'($urandom), 6);
      // Duplicate symbol spoils the alphabet
      send_beat(OP_APPEND, "0", $urandom);
      send_beat(OP_CONVERT, SYM_W'($urandom), 7);
      // Edges of the printable range
      send_beat(OP_START, 8'h00, '0);
      send_beat(OP_APPEND, SYM_W'(CHAR_CTRL_MAX + 1), $urandom);
      send_beat(OP_APPEND, SYM_W'(CHAR_DEL - 1), $urandom);
      send_beat(OP_CONVERT, SYM_W'($urandom), 123456);
      // Sign characters and out-of-range symbols are rejected
      send_beat(OP_APPEND, CHAR_PLUS, $urandom);
      send_beat(OP_CONVERT, SYM_W'($urandom), 9);
      send_beat(OP_START, SYM_W'($urandom), $urandom);
      send_beat(OP_APPEND, "a", $urandom);
      send_beat(OP_APPEND, CHAR_MINUS, $urandom);
      send_beat(OP_CONVERT, SYM_W'($urandom), -32'sd9);
      send_beat(OP_START, SYM_W'($urandom), $urandom);
      send_beat(OP_APPEND, CHAR_CTRL_MAX, $urandom);
      send_beat(OP_APPEND, CHAR_DEL, $urandom);
      send_beat(OP_CONVERT, SYM_W'($urandom), 10);
      wait_for_text();

      // Random: mostly clean alphabets with conversions, plus broken runs and noise
      while (items_sent < ITEM_TARGET) begin
         if (!paused && items_sent >= ITEM_TARGET / 2) begin
            wait_for_text();
            paused = 1'b1;
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               load_alphabet(alpha_size(), -1);
               send_converts($urandom_range(1, 8));
            end
            6: begin
               size = alpha_size();
               load_alphabet(size, $urandom_range(1, size));
               send_converts($urandom_range(1, 3));
            end
            7: begin
               repeat ($urandom_range(1, 6))
                  send_beat(OP_W'($urandom_range(0, 3)), SYM_W'($urandom), $urandom);
            end
            8: send_converts($urandom_range(1, 6));
            default: begin
               if (!overfilled) begin
                  // Run past the alphabet capacity once
                  send_beat(OP_START, SYM_W'($urandom), $urandom);
                  for (int i = 0; i <= SICRT_ALPHA_MAX; i++)
                     send_beat(OP_APPEND, SYM_W'(i), $urandom);
                  send_converts(2);
                  overfilled = 1'b1;
               end else begin
                  load_alphabet(2, -1);
                  send_converts($urandom_range(1, 4));
               end
            end
         endcase
      end
      req_tvalid <= 1'b0;

      // Drain, then let any silent conversion finish
      @(posedge clock);
      while (chars_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && chars_pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
